FILE: rtl/core/mcpc_pkg.sv
// Shared types and constants for the multi-channel pulse counter.
// No dependencies; used by every module of the block except mcpc_ram.
package mcpc_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_TIME_WIDTH   = 48;
  localparam int COUNT_W          = 32;  // channel and global pulse counts
  localparam int PIN_W            = 8;   // pins carried by a sample request
  localparam int CHAN_FIELD_W     = 3;   // channel fields on the streams
  localparam int APB_DATA_W       = 32;
  localparam int PADDR_W          = 3;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_PRELOAD = 1'b1
  } cmd_t;

  // Register index, i.e. paddr[PADDR_W-1:2]
  typedef enum logic [PADDR_W-3:0] {
    REG_CHANNEL_ENABLE = 1'b0
  } reg_idx_t;

  // Control of one operation handed from the issue stage to the update stage
  typedef struct packed {
    logic valid;
    logic is_edge;  // 1: counted edge, 0: preload write
    logic last;     // final edge of its sample; also set for a preload
  } op_ctrl_t;

endpackage

FILE: rtl/core/mcpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mcpc_issue.sv
// Issue stage: edge detection, pin history, and one RAM read per edge or preload.
// Depends on mcpc_pkg.
module mcpc_issue #(
  parameter int NUM_CHANNELS = mcpc_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_WIDTH   = mcpc_pkg::DEF_TIME_WIDTH,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [mcpc_pkg::PIN_W-1:0]         in_levels,
  input  logic [TIME_WIDTH-1:0]              in_time,
  input  logic [mcpc_pkg::CHAN_FIELD_W-1:0]  in_channel,
  input  logic [mcpc_pkg::COUNT_W-1:0]       in_count,
  input  logic [TIME_WIDTH-1:0]              in_ptime,
  input  logic [TIME_WIDTH-1:0]              in_pperiod,
  input  logic [mcpc_pkg::PIN_W-1:0]         channel_enable,
  input  logic                               can_issue,
  output mcpc_pkg::op_ctrl_t                 op,
  output logic [CH_W-1:0]                    op_ch,
  output logic [TIME_WIDTH-1:0]              op_time,
  output logic [mcpc_pkg::COUNT_W-1:0]       op_count,
  output logic [TIME_WIDTH-1:0]              op_ptime,
  output logic [TIME_WIDTH-1:0]              op_pperiod
);

  logic                         busy;
  logic                         is_preload;
  logic [NUM_CHANNELS-1:0]      mask;
  logic [NUM_CHANNELS-1:0]      prev_level;
  logic [NUM_CHANNELS-1:0]      new_level;
  logic [NUM_CHANNELS-1:0]      edges;
  logic [NUM_CHANNELS-1:0]      lowest;
  logic [NUM_CHANNELS-1:0]      rest;
  logic [CH_W-1:0]              low_idx;
  logic [CH_W-1:0]              pre_ch;
  logic [TIME_WIDTH-1:0]        sample_time;
  logic [mcpc_pkg::COUNT_W-1:0] pre_count;
  logic [TIME_WIDTH-1:0]        pre_time;
  logic [TIME_WIDTH-1:0]        pre_period;
  logic                         issue;
  logic                         finishing;
  logic                         accept;
  logic                         preload_in;
  logic                         ch_ok;

  // channels past the pin width read low and never count
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lvl
    if (i < mcpc_pkg::PIN_W) begin : g_pin
      assign new_level[i] = in_levels[i];
      assign edges[i]     = in_levels[i] & channel_enable[i] & ~prev_level[i];
    end else begin : g_none
      assign new_level[i] = 1'b0;
      assign edges[i]     = 1'b0;
    end
  end

  assign lowest = mask & (~mask + NUM_CHANNELS'(1));
  assign rest   = mask & ~lowest;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (lowest[i]) begin
        low_idx = low_idx | CH_W'(i);
      end
    end
  end

  assign issue      = busy & can_issue;
  assign finishing  = issue & (is_preload | (rest == '0));
  assign in_ready   = ~busy | finishing;
  assign accept     = in_valid & in_ready;
  assign preload_in = (in_cmd == mcpc_pkg::CMD_PRELOAD);
  assign ch_ok      = 32'(in_channel) < 32'(NUM_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      prev_level <= '0;
    end else if (accept) begin
      if (preload_in) begin
        busy <= ch_ok;
      end else begin
        busy       <= |edges;
        prev_level <= new_level;
      end
    end else if (finishing) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_preload  <= preload_in;
      mask        <= edges;
      sample_time <= in_time;
      pre_ch      <= CH_W'(in_channel);
      pre_count   <= in_count;
      pre_time    <= in_ptime;
      pre_period  <= in_pperiod;
    end else if (issue) begin
      mask <= rest;
    end
  end

  assign op.valid   = issue;
  assign op.is_edge = ~is_preload;
  assign op.last    = is_preload | (rest == '0);
  assign op_ch      = is_preload ? pre_ch : low_idx;
  assign op_time    = sample_time;
  assign op_count   = pre_count;
  assign op_ptime   = pre_time;
  assign op_pperiod = pre_period;

  a_busy_has_edges: assert property (@(posedge clk) disable iff (rst)
    busy && !is_preload |-> mask != '0)
    else $error("sample pending with no edges left");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.last && !accept |=> !busy)
    else $error("issue stage still busy after its final operation");

endmodule

FILE: rtl/core/mcpc_update.sv
// Update stage: read-modify-write of the channel entry, forwarding,
// global count and the result register. Depends on mcpc_pkg.
module mcpc_update #(
  parameter int NUM_CHANNELS = mcpc_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_WIDTH   = mcpc_pkg::DEF_TIME_WIDTH,
  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int ENTRY_W = mcpc_pkg::COUNT_W + 2 * TIME_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcpc_pkg::op_ctrl_t                op,
  input  logic [CH_W-1:0]                   op_ch,
  input  logic [TIME_WIDTH-1:0]             op_time,
  input  logic [mcpc_pkg::COUNT_W-1:0]      op_count,
  input  logic [TIME_WIDTH-1:0]             op_ptime,
  input  logic [TIME_WIDTH-1:0]             op_pperiod,
  output logic                              can_accept,
  input  logic [ENTRY_W-1:0]                rd_data,
  output logic                              wr_en,
  output logic [CH_W-1:0]                   wr_addr,
  output logic [ENTRY_W-1:0]                wr_data,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [mcpc_pkg::CHAN_FIELD_W-1:0] m_channel,
  output logic [mcpc_pkg::COUNT_W-1:0]      m_count,
  output logic [TIME_WIDTH-1:0]             m_period,
  output logic [TIME_WIDTH-1:0]             m_edge_time,
  output logic [mcpc_pkg::COUNT_W-1:0]      m_total,
  output logic                              m_last
);

  mcpc_pkg::op_ctrl_t           s2;
  logic [CH_W-1:0]              s2_ch;
  logic [TIME_WIDTH-1:0]        s2_time;
  logic [mcpc_pkg::COUNT_W-1:0] s2_count;
  logic [TIME_WIDTH-1:0]        s2_ptime;
  logic [TIME_WIDTH-1:0]        s2_pperiod;
  logic                         fwd_hit;
  logic [ENTRY_W-1:0]           fwd_data;
  logic [NUM_CHANNELS-1:0]      entry_valid;
  logic [mcpc_pkg::COUNT_W-1:0] global_count;
  logic [ENTRY_W-1:0]           old_entry;
  logic [mcpc_pkg::COUNT_W-1:0] old_count;
  logic [TIME_WIDTH-1:0]        old_time;
  logic [mcpc_pkg::COUNT_W-1:0] new_count;
  logic [TIME_WIDTH-1:0]        new_period;
  logic                         out_free;
  logic                         advance;
  logic                         out_load;

  assign out_free   = ~m_valid | m_ready;
  assign advance    = s2.valid & (~s2.is_edge | out_free);
  assign out_load   = advance & s2.is_edge;
  assign can_accept = ~s2.valid | advance;

  // entry never written reads as zero; a write in the read cycle is forwarded
  always_comb begin
    if (fwd_hit) begin
      old_entry = fwd_data;
    end else if (entry_valid[s2_ch]) begin
      old_entry = rd_data;
    end else begin
      old_entry = '0;
    end
  end

  assign old_count  = old_entry[ENTRY_W-1 -: mcpc_pkg::COUNT_W];
  assign old_time   = old_entry[2*TIME_WIDTH-1 -: TIME_WIDTH];
  assign new_count  = old_count + mcpc_pkg::COUNT_W'(1);
  assign new_period = s2_time - old_time;

  assign wr_en   = advance;
  assign wr_addr = s2_ch;
  assign wr_data = s2.is_edge ? {new_count, s2_time, new_period}
                              : {s2_count, s2_ptime, s2_pperiod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2           <= '0;
      fwd_hit      <= 1'b0;
      entry_valid  <= '0;
      global_count <= '0;
      m_valid      <= 1'b0;
    end else begin
      if (op.valid) begin
        s2      <= op;
        fwd_hit <= wr_en && (wr_addr == op_ch);
      end else if (advance) begin
        s2.valid <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        global_count <= global_count + mcpc_pkg::COUNT_W'(1);
        m_valid      <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      s2_ch      <= op_ch;
      s2_time    <= op_time;
      s2_count   <= op_count;
      s2_ptime   <= op_ptime;
      s2_pperiod <= op_pperiod;
      fwd_data   <= wr_data;
    end
    if (out_load) begin
      m_channel   <= mcpc_pkg::CHAN_FIELD_W'(s2_ch);
      m_count     <= new_count;
      m_period    <= new_period;
      m_edge_time <= s2_time;
      m_total     <= global_count + mcpc_pkg::COUNT_W'(1);
      m_last      <= s2.last;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    op.valid |-> can_accept)
    else $error("operation issued into a stalled update stage");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_valid && m_total == global_count)
    else $error("result total does not match global count");

endmodule

FILE: rtl/core/multi_channel_pulse_counter_unit.sv
// Top level of the multi-channel pulse counter: APB register, request
// unpacking and the issue / update / RAM pipeline.
// Depends on mcpc_pkg, mcpc_ram, mcpc_issue, mcpc_update.
//
// Counts rising edges on up to NUM_CHANNELS pulse inputs. Each sample request
// carries all pin levels and a microsecond timestamp; every enabled channel
// whose pin went 0 -> 1 bumps its own count and the global count, captures
// the period since its previous edge (wrapping modulo 2^TIME_WIDTH) and
// stores the new edge time. One result leaves per edge, lowest channel
// first, with tlast on the final one; a sample with no edge gives nothing.
// A preload request overwrites one channel's count, edge time and period.
// Per-channel state lives in one RAM entry (count, edge time, period) that
// is read, updated and written back; a per-entry valid bit makes every entry
// read as zero after reset, so there is no clearing pass. The issue stage
// makes one RAM read per cycle while the update stage can accept: one per
// edge of a sample and one per preload; an edgeless sample makes none. The
// next request is taken in the cycle its predecessor issues its last read.
// An edge whose result cannot enter the result register (m_tready low with
// a result still waiting) holds the update stage, and that stalls the issue
// stage and the request side until the register frees. A result passes the
// issue, update and result registers. Back-to-back updates to the same
// channel are forwarded around the RAM. channel_enable (address 0) should
// only be changed while no request is in flight.
module multi_channel_pulse_counter_unit #(
  parameter int NUM_CHANNELS = mcpc_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_WIDTH   = mcpc_pkg::DEF_TIME_WIDTH,
  localparam int IN_BITS  = mcpc_pkg::PIN_W + mcpc_pkg::CHAN_FIELD_W
                          + mcpc_pkg::COUNT_W + 3 * TIME_WIDTH,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * mcpc_pkg::COUNT_W + 2 * TIME_WIDTH,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcpc_pkg::PADDR_W-1:0]      paddr,
  input  logic [mcpc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mcpc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pin_levels, timestamp_us, channel, preload_count, preload_time,
  // preload_period, zero pad
  input  logic [IN_W-1:0]                   s_tdata,
  // cmd
  input  logic                              s_tuser,
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // channel_count, period_us, edge_time, total_pulses, any zero pad
  output logic [OUT_W-1:0]                  m_tdata,
  // edge_channel
  output logic [mcpc_pkg::CHAN_FIELD_W-1:0] m_tuser,
  output logic                              m_tlast
);

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ENTRY_W = mcpc_pkg::COUNT_W + 2 * TIME_WIDTH;
  // request field offsets, lowest first
  localparam int OFF_TS  = mcpc_pkg::PIN_W;
  localparam int OFF_CH  = OFF_TS + TIME_WIDTH;
  localparam int OFF_PC  = OFF_CH + mcpc_pkg::CHAN_FIELD_W;
  localparam int OFF_PT  = OFF_PC + mcpc_pkg::COUNT_W;
  localparam int OFF_PP  = OFF_PT + TIME_WIDTH;

  logic [mcpc_pkg::PIN_W-1:0]   channel_enable;
  logic [mcpc_pkg::PADDR_W-3:0] reg_idx;
  logic                         cfg_write;

  mcpc_pkg::op_ctrl_t           op;
  logic [CH_W-1:0]              op_ch;
  logic [TIME_WIDTH-1:0]        op_time;
  logic [mcpc_pkg::COUNT_W-1:0] op_count;
  logic [TIME_WIDTH-1:0]        op_ptime;
  logic [TIME_WIDTH-1:0]        op_pperiod;
  logic                         can_accept;
  logic [ENTRY_W-1:0]           rd_data;
  logic                         wr_en;
  logic [CH_W-1:0]              wr_addr;
  logic [ENTRY_W-1:0]           wr_data;

  logic [mcpc_pkg::COUNT_W-1:0] out_count;
  logic [TIME_WIDTH-1:0]        out_period;
  logic [TIME_WIDTH-1:0]        out_edge_time;
  logic [mcpc_pkg::COUNT_W-1:0] out_total;

  // ---- APB register: word-aligned decode, always ready ----
  assign pready    = 1'b1;
  assign reg_idx   = paddr[mcpc_pkg::PADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '0;
    end else if (cfg_write && reg_idx == mcpc_pkg::REG_CHANNEL_ENABLE) begin
      channel_enable <= pwdata[mcpc_pkg::PIN_W-1:0];
    end
  end

  assign prdata = (reg_idx == mcpc_pkg::REG_CHANNEL_ENABLE)
                ? mcpc_pkg::APB_DATA_W'(channel_enable) : '0;

  // ---- issue: edge detect, one RAM read per edge or preload ----
  mcpc_issue #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_issue (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_cmd        (s_tuser),
    .in_levels     (s_tdata[mcpc_pkg::PIN_W-1:0]),
    .in_time       (s_tdata[OFF_TS +: TIME_WIDTH]),
    .in_channel    (s_tdata[OFF_CH +: mcpc_pkg::CHAN_FIELD_W]),
    .in_count      (s_tdata[OFF_PC +: mcpc_pkg::COUNT_W]),
    .in_ptime      (s_tdata[OFF_PT +: TIME_WIDTH]),
    .in_pperiod    (s_tdata[OFF_PP +: TIME_WIDTH]),
    .channel_enable(channel_enable),
    .can_issue     (can_accept),
    .op            (op),
    .op_ch         (op_ch),
    .op_time       (op_time),
    .op_count      (op_count),
    .op_ptime      (op_ptime),
    .op_pperiod    (op_pperiod)
  );

  // ---- channel state: {count, edge time, period} per channel ----
  mcpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_CHANNELS)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (op.valid),
    .rd_addr(op_ch),
    .rd_data(rd_data)
  );

  // ---- update: modify, write back, drive the result register ----
  mcpc_update #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .op_ch      (op_ch),
    .op_time    (op_time),
    .op_count   (op_count),
    .op_ptime   (op_ptime),
    .op_pperiod (op_pperiod),
    .can_accept (can_accept),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_channel  (m_tuser),
    .m_count    (out_count),
    .m_period   (out_period),
    .m_edge_time(out_edge_time),
    .m_total    (out_total),
    .m_last     (m_tlast)
  );

  assign m_tdata = OUT_W'({out_total, out_edge_time, out_period, out_count});

endmodule

FILE: dv/pulse_edge_checker.sv
`timescale 1ns / 100ps
// Watches the APB port and both streams of the pulse counter, predicts the edge
// reports each sample request causes, and checks them in order.
// Depends on mcpc_pkg.
module pulse_edge_checker
  import mcpc_pkg::*;
#(
  parameter int TW    = DEF_TIME_WIDTH,
  parameter int IN_W  = 192,
  parameter int OUT_W = 160
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  input  logic                    pready,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [IN_W-1:0]         s_tdata,
  input  logic                    s_tuser,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OUT_W-1:0]        m_tdata,
  input  logic [CHAN_FIELD_W-1:0] m_tuser,
  input  logic                    m_tlast,
  output int                      fail_count,
  output int                      pending
);

  localparam int NCH = DEF_NUM_CHANNELS;

  typedef struct packed {
    logic [CHAN_FIELD_W-1:0] chan;
    logic [COUNT_W-1:0]      count;
    logic [TW-1:0]           period;
    logic [TW-1:0]           stamp;
    logic [COUNT_W-1:0]      total;
    logic                    is_last;
  } edge_rpt_t;

  logic [NCH-1:0]     enable_mask;
  logic [NCH-1:0]     prev_pins;
  logic [COUNT_W-1:0] chan_count [NCH];
  logic [TW-1:0]      chan_stamp [NCH];
  logic [TW-1:0]      chan_period[NCH];
  logic [COUNT_W-1:0] global_total;
  edge_rpt_t          edge_q[$];
  edge_rpt_t          want;
  int                 mismatches = 0;

  // Request layout: pins, timestamp, channel, count, time, period
  task automatic predict_request(input logic [IN_W-1:0] d, input logic cmd);
    logic [PIN_W-1:0]        pins;
    logic [TW-1:0]           now_us;
    logic [CHAN_FIELD_W-1:0] ch;
    edge_rpt_t               r;
    edge_rpt_t               batch[$];
    pins   = d[PIN_W-1:0];
    now_us = d[PIN_W +: TW];
    ch     = d[PIN_W+TW +: CHAN_FIELD_W];
    if (cmd_t'(cmd) == CMD_PRELOAD) begin
      chan_count[ch]  = d[PIN_W+TW+CHAN_FIELD_W +: COUNT_W];
      chan_stamp[ch]  = d[PIN_W+TW+CHAN_FIELD_W+COUNT_W +: TW];
      chan_period[ch] = d[PIN_W+2*TW+CHAN_FIELD_W+COUNT_W +: TW];
      return;
    end
    for (int i = 0; i < NCH; i++) begin
      if (enable_mask[i] && pins[i] && !prev_pins[i]) begin
        chan_period[i] = now_us - chan_stamp[i];
        chan_stamp[i]  = now_us;
        chan_count[i]  = chan_count[i] + 1'b1;
        global_total   = global_total + 1'b1;
        r.chan    = CHAN_FIELD_W'(i);
        r.count   = chan_count[i];
        r.period  = chan_period[i];
        r.stamp   = now_us;
        r.total   = global_total;
        r.is_last = 1'b0;
        batch.push_back(r);
      end
      prev_pins[i] = pins[i];
    end
    if (batch.size() > 0) batch[batch.size()-1].is_last = 1'b1;
    foreach (batch[k]) edge_q.push_back(batch[k]);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      enable_mask  = '0;
      prev_pins    = '0;
      global_total = '0;
      for (int i = 0; i < NCH; i++) begin
        chan_count[i]  = '0;
        chan_stamp[i]  = '0;
        chan_period[i] = '0;
      end
      edge_q.delete();
    end else begin
      // a request taken at this edge still sees the old enable mask
      if (s_tvalid && s_tready) predict_request(s_tdata, s_tuser);
      if (psel && penable && pwrite && pready &&
          reg_idx_t'(paddr[PADDR_W-1:2]) == REG_CHANNEL_ENABLE)
        enable_mask = pwdata[NCH-1:0];
      if (m_tvalid && m_tready) begin
        if (edge_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, channel %0d count %0h", $time,
                   m_tuser, m_tdata[COUNT_W-1:0]);
        end else begin
          want = edge_q.pop_front();
          check_field("edge_channel", want.chan, m_tuser);
          check_field("channel_count", want.count, m_tdata[COUNT_W-1:0]);
          check_field("period_us", want.period, m_tdata[COUNT_W +: TW]);
          check_field("edge_time", want.stamp, m_tdata[COUNT_W+TW +: TW]);
          check_field("total_pulses", want.total, m_tdata[COUNT_W+2*TW +: COUNT_W]);
          check_field("last", want.is_last, m_tlast);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= edge_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the multi-channel pulse counter.
// Depends on mcpc_pkg, multi_channel_pulse_counter_unit and pulse_edge_checker.
module tb_top;
  import mcpc_pkg::*;

  localparam int TW    = DEF_TIME_WIDTH;
  localparam int IN_W  = ((PIN_W + CHAN_FIELD_W + COUNT_W + 3 * TW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * COUNT_W + 2 * TW + 7) / 8) * 8;
  localparam logic [TW-1:0] TIME_MAX = '1;

  logic                    clk;
  logic                    rst      = 1'b1;
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [PADDR_W-1:0]      paddr    = '0;
  logic [APB_DATA_W-1:0]   pwdata   = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_W-1:0]         s_tdata  = '0;
  logic                    s_tuser  = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_W-1:0]        m_tdata;
  logic [CHAN_FIELD_W-1:0] m_tuser;
  logic                    m_tlast;

  int            fail_count;
  int            pending;
  bit            quiet = 1'b0;    // no idling on either side while set
  logic [TW-1:0] sample_us = '0;  // running timestamp of random samples

  multi_channel_pulse_counter_unit i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  pulse_edge_checker #(.TW(TW), .IN_W(IN_W), .OUT_W(OUT_W)) i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls about a quarter of the time unless quiet is set.
  always @(posedge clk) m_tready <= quiet || ($urandom_range(99) >= 26);

  // Hard stop: a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TW-1:0];
  endfunction

  // Counts near the wrap point are worth hitting often.
  function automatic logic [COUNT_W-1:0] rand_count();
    if ($urandom_range(3) == 0) return 32'hFFFF_FFFF - $urandom_range(3);
    return $urandom;
  endfunction

  function automatic logic [PIN_W-1:0] rand_pins();
    if ($urandom_range(99) < 15) return $urandom_range(1) ? 8'hFF : 8'h00;
    return PIN_W'($urandom);
  endfunction

  // Pack fields lowest first; pad bits stay zero.
  function automatic logic [IN_W-1:0] pack_request(
      input logic [PIN_W-1:0] pins, input logic [TW-1:0] stamp,
      input logic [CHAN_FIELD_W-1:0] ch, input logic [COUNT_W-1:0] cnt,
      input logic [TW-1:0] etime, input logic [TW-1:0] period);
    logic [IN_W-1:0] d;
    d = '0;
    d[PIN_W + 3*TW + CHAN_FIELD_W + COUNT_W - 1:0] = {period, etime, cnt, ch, stamp, pins};
    return d;
  endfunction

  // Present one request and hold it until accepted. tvalid is left high so a
  // following request goes out back to back; a gap lowers it first.
  task automatic issue_request(input cmd_t cmd, input logic [IN_W-1:0] d);
    while (!quiet && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Preload-only fields get random filler so their bits toggle on samples too.
  task automatic send_sample(input logic [PIN_W-1:0] pins, input logic [TW-1:0] stamp);
    issue_request(CMD_SAMPLE, pack_request(pins, stamp, CHAN_FIELD_W'($urandom),
                                           $urandom, rand_time(), rand_time()));
  endtask

  task automatic send_preload(input logic [CHAN_FIELD_W-1:0] ch,
                              input logic [COUNT_W-1:0] cnt,
                              input logic [TW-1:0] etime, input logic [TW-1:0] period);
    issue_request(CMD_PRELOAD, pack_request(PIN_W'($urandom), rand_time(), ch, cnt,
                                            etime, period));
  endtask

  // Drop tvalid, let every expected result drain, then allow for a preload
  // that may still be in the issue or update stage.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase APB write of the enable mask; block must be idle.
  task automatic write_enable(input logic [PIN_W-1:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CHANNEL_ENABLE, 2'b00};
    pwdata  <= APB_DATA_W'(mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly samples with a rising timestamp, some jumps anywhere in the range
  // (so periods wrap) and a sprinkling of preloads.
  task automatic random_phase(input int n_req, input int hold_at);
    for (int k = 0; k < n_req; k++) begin
      if (k == hold_at) drain();
      if ($urandom_range(99) < 10) begin
        send_preload(CHAN_FIELD_W'($urandom), rand_count(), rand_time(), rand_time());
      end else begin
        if ($urandom_range(99) < 5) sample_us = rand_time();
        else sample_us = sample_us + $urandom_range(1, 5000);
        send_sample(rand_pins(), sample_us);
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All channels disabled after reset: pins go high, nothing is counted,
    // but the previous levels follow them.
    send_sample(8'hFF, 48'd10);
    drain();
    write_enable(8'hFF);

    // Enabled while pins are already high: still no edge.
    send_sample(8'hFF, 48'd20);
    send_sample(8'h00, 48'd30);
    // Every channel at once, period measured from the reset time of zero.
    send_sample(8'hFF, 48'd1000);
    send_sample(8'h00, 48'd1001);
    // Preload channel 0 at the top of every range: count and period wrap.
    send_preload(3'd0, 32'hFFFF_FFFF, TIME_MAX, TIME_MAX);
    send_preload(3'd7, '0, '0, '0);
    send_sample(8'h81, 48'd5);
    send_sample(8'h00, rand_time());
    // Largest timestamp, then interleaved halves (falling pins make no edge).
    send_sample(8'h55, TIME_MAX);
    send_sample(8'hAA, TIME_MAX);
    send_sample(8'h00, '0);
    send_sample(8'h01, '0);
    // Preload with random values, then an edge on that channel.
    send_preload(3'd3, rand_count(), rand_time(), rand_time());
    send_sample(8'h08, rand_time());
    send_sample(8'h00, rand_time());
    drain();

    // Random part over several enable settings.
    write_enable(PIN_W'($urandom));
    random_phase(50, -1);
    write_enable(8'h00);
    random_phase(10, -1);
    // Long stretch with no idling at all.
    write_enable(8'hFF);
    quiet = 1'b1;
    random_phase(50, -1);
    quiet = 1'b0;
    // Sender holds mid-phase until everything has come back.
    write_enable(PIN_W'($urandom));
    random_phase(50, 25);
    write_enable(PIN_W'($urandom) | 8'h81);
    random_phase(50, -1);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
